### hdl/mftt_pkg.sv
package mftt_pkg;

  // stream and field widths
  localparam int ID_W      = 11;
  localparam int BYTE_W    = 8;
  localparam int ENC_W     = 16;
  localparam int WORD_W    = 16;
  localparam int TURN_W    = 16;
  localparam int THR_W     = 13;
  localparam int SERIES_W  = 30;
  localparam int ANGLE_W   = 23;
  localparam int SANGLE_W  = 35;
  localparam int IN_DATA_W = 72;

  // register map
  localparam int          REG_ADDR_W  = 3;
  localparam logic        REG_BASE_ID = 1'b0;
  localparam logic        REG_WRAP    = 1'b1;
  localparam logic [10:0] BASE_RESET  = 11'h201;
  localparam logic [12:0] WRAP_RESET  = 13'd6400;

  // encoder and angle scaling, degrees in q10
  localparam int COUNTS_PER_TURN  = 8192;
  localparam int COUNT_SHIFT      = 13;
  localparam int DEG_FULL_Q10     = 368640;
  localparam int DEG_HALF_Q10     = 184320;
  localparam int DEG_PER_COUNT    = DEG_FULL_Q10 / COUNTS_PER_TURN;

  localparam logic signed [15:0] TURN_MAX = 16'sh7fff;
  localparam logic signed [15:0] TURN_MIN = -16'sh8000;

  typedef struct packed {
    logic [15:0]        encoder;
    logic signed [15:0] motor_speed;
    logic signed [15:0] current_value;
    logic [7:0]         temperature;
  } fb_fields_t;

endpackage

### hdl/mftt_regs.sv
module mftt_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mftt_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic [mftt_pkg::ID_W-1:0]      base_frame_id,
  output logic [mftt_pkg::THR_W-1:0]     wrap_threshold
);
  import mftt_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame_id  <= BASE_RESET;
      wrap_threshold <= WRAP_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE_ID: base_frame_id  <= pwdata[ID_W-1:0];
        REG_WRAP:    wrap_threshold <= pwdata[THR_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE_ID: prdata = {{(32-ID_W){1'b0}}, base_frame_id};
      REG_WRAP:    prdata = {{(32-THR_W){1'b0}}, wrap_threshold};
      default:     prdata = '0;
    endcase
  end

endmodule

### hdl/mftt_tracker.sv
module mftt_tracker #(
  parameter int MOTOR_COUNT = 4,
  parameter int MIDX_W      = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            update,
  input  logic [MIDX_W-1:0]               idx,
  input  logic [mftt_pkg::ENC_W-1:0]      encoder,
  input  logic [mftt_pkg::THR_W-1:0]      wrap_threshold,
  output logic signed [mftt_pkg::TURN_W-1:0] turn_next
);
  import mftt_pkg::*;

  logic [ENC_W-1:0]         previous_encoder [MOTOR_COUNT];
  logic signed [TURN_W-1:0] turns [MOTOR_COUNT];

  logic signed [ENC_W:0]    diff;
  logic signed [ENC_W:0]    thr;
  logic signed [TURN_W-1:0] turn_cur;

  assign turn_cur = turns[idx];
  assign diff     = $signed({1'b0, encoder}) - $signed({1'b0, previous_encoder[idx]});
  assign thr      = $signed({{(ENC_W+1-THR_W){1'b0}}, wrap_threshold});

  // big drop wraps forward, big rise wraps back, count saturates
  always_comb begin
    turn_next = turn_cur;
    if (diff < -thr) begin
      if (turn_cur != TURN_MAX) turn_next = turn_cur + 16'sd1;
    end else if (diff > thr) begin
      if (turn_cur != TURN_MIN) turn_next = turn_cur - 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        previous_encoder[k] <= '0;
        turns[k]            <= '0;
      end
    end else if (update) begin
      previous_encoder[idx] <= encoder;
      turns[idx]            <= turn_next;
    end
  end

endmodule

### hdl/mftt_result.sv
module mftt_result #(
  parameter int MIDX_W = 2,
  parameter int OUT_W  = 168
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [MIDX_W-1:0]                idx,
  input  mftt_pkg::fb_fields_t             fields,
  input  logic signed [mftt_pkg::TURN_W-1:0] turn,
  output logic                             free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [OUT_W-1:0]                 m_tdata
);
  import mftt_pkg::*;

  localparam int USED_W = MIDX_W + ENC_W + 2 * WORD_W + BYTE_W + TURN_W
                          + SERIES_W + ANGLE_W + SANGLE_W;
  localparam int TDEG_W = SANGLE_W - COUNT_SHIFT;

  logic [SERIES_W-1:0]        turn_ext30;
  logic [SERIES_W-1:0]        series_encoder;
  logic [ANGLE_W-2:0]         enc_deg;
  logic [ANGLE_W-1:0]         angle_q10;
  logic signed [TDEG_W-1:0]   turn_ext22;
  logic signed [TDEG_W-1:0]   turn_deg45;
  logic signed [SANGLE_W-1:0] turn_deg;
  logic [SANGLE_W-1:0]        series_angle_q10;
  logic [USED_W-1:0]          packed_res;

  assign free = !m_tvalid || m_tready;

  assign turn_ext30     = {{(SERIES_W-TURN_W){turn[TURN_W-1]}}, turn};
  assign series_encoder = {{(SERIES_W-ENC_W){1'b0}}, fields.encoder}
                        + {turn_ext30[SERIES_W-COUNT_SHIFT-1:0], {COUNT_SHIFT{1'b0}}};

  // counts to degrees is an exact integer ratio
  assign enc_deg   = (ANGLE_W-1)'(fields.encoder * (ANGLE_W-1)'(DEG_PER_COUNT));
  assign angle_q10 = {1'b0, enc_deg} - ANGLE_W'(DEG_HALF_Q10);

  // a full turn in q10 degrees is 45 shifted up by the count width
  assign turn_ext22       = {{(TDEG_W-TURN_W){turn[TURN_W-1]}}, turn};
  assign turn_deg45       = turn_ext22 * $signed(TDEG_W'(DEG_PER_COUNT));
  assign turn_deg         = {turn_deg45, {COUNT_SHIFT{1'b0}}};
  assign series_angle_q10 = {{(SANGLE_W-ANGLE_W){angle_q10[ANGLE_W-1]}}, angle_q10}
                          + turn_deg;

  assign packed_res = {series_angle_q10, angle_q10, series_encoder, turn,
                       fields.temperature, fields.current_value, fields.motor_speed,
                       fields.encoder, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(OUT_W-USED_W){1'b0}}, packed_res};
    end
  end

endmodule

### hdl/motor_feedback_frame_turn_tracker_top.sv
// channel    | dir | handshake                   | payload
// -----------+-----+-----------------------------+------------------------------------
// frame in   | in  | s_tvalid / s_tready         | s_tdata: id, payload bytes 0..6
// result out | out | m_tvalid / m_tready         | m_tdata: decoded feedback, turn state
// config     | in  | psel, penable, pwrite/pready| paddr, pwdata, prdata (2 registers)
//
// one frame per cycle sustained while the result register is free; a matching frame's
// result is offered after it passes the input register, then the result register
// the per-motor turn update is a read-modify-write in the input-register stage,
// so back-to-back frames for one motor see each other's state
// frames with a foreign id leave the input register without waiting on m_tready
// rst is synchronous: registers reset, turn and encoder history clear to zero
module motor_feedback_frame_turn_tracker_top #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  // slave stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // [10:0] frame_id, [18:11] payload_byte0, [26:19] payload_byte1,
  // [34:27] payload_byte2, [42:35] payload_byte3, [50:43] payload_byte4,
  // [58:51] payload_byte5, [66:59] payload_byte6, rest zero
  input  logic [mftt_pkg::IN_DATA_W-1:0] s_tdata,
  // master stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // from bit 0 up: motor_index, encoder, motor_speed, current_value, temperature,
  // turn_count, series_encoder, angle_q10, series_angle_q10, zero fill
  output logic [((((MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1) + 160 + 7) / 8) * 8 - 1:0]
                              m_tdata,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [mftt_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mftt_pkg::*;

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int OUT_W  = ((MIDX_W + 160 + 7) / 8) * 8;

  logic [ID_W-1:0]  base_frame_id;
  logic [THR_W-1:0] wrap_threshold;

  // input register
  logic               in_valid;
  logic [ID_W-1:0]    in_id;
  fb_fields_t         in_fields;

  logic [ID_W:0]             rel_id;
  logic                      hit;
  logic [MIDX_W-1:0]         idx;
  logic                      res_free;
  logic                      advance;
  logic                      take;
  logic signed [TURN_W-1:0]  turn_next;

  assign pready = 1'b1;

  mftt_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .base_frame_id  (base_frame_id),
    .wrap_threshold (wrap_threshold)
  );

  // id match: base <= id < base + MOTOR_COUNT
  assign rel_id = {1'b0, in_id} - {1'b0, base_frame_id};
  assign hit    = !rel_id[ID_W] && (rel_id[ID_W-1:0] < ID_W'(MOTOR_COUNT));
  assign idx    = rel_id[MIDX_W-1:0];

  // a foreign frame always leaves, a match waits for the result register
  assign take     = in_valid && hit && res_free;
  assign advance  = in_valid && (!hit || res_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_id                   <= s_tdata[10:0];
      in_fields.encoder       <= {s_tdata[18:11], s_tdata[26:19]};
      in_fields.motor_speed   <= {s_tdata[34:27], s_tdata[42:35]};
      in_fields.current_value <= {s_tdata[50:43], s_tdata[58:51]};
      in_fields.temperature   <= s_tdata[66:59];
    end
  end

  mftt_tracker #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .MIDX_W      (MIDX_W)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .update         (take),
    .idx            (idx),
    .encoder        (in_fields.encoder),
    .wrap_threshold (wrap_threshold),
    .turn_next      (turn_next)
  );

  mftt_result #(
    .MIDX_W (MIDX_W),
    .OUT_W  (OUT_W)
  ) u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .idx      (idx),
    .fields   (in_fields),
    .turn     (turn_next),
    .free     (res_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### hdl/mftt_checker.sv
module mftt_checker #(
  parameter int MOTOR_COUNT = 4
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((((MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1) + 160 + 7) / 8) * 8 - 1:0]
              m_tdata,
  input logic pready
);
  import mftt_pkg::*;

  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ENC_LO = MIDX_W;
  localparam int TRN_LO = MIDX_W + ENC_W + 2 * WORD_W + BYTE_W;
  localparam int SER_LO = TRN_LO + TURN_W;

  logic [MIDX_W-1:0]   mon_idx;
  logic [ENC_W-1:0]    mon_enc;
  logic [TURN_W-1:0]   mon_turn;
  logic [SERIES_W-1:0] mon_series;
  logic [SERIES_W-1:0] mon_turn_ext;
  logic [SERIES_W-1:0] mon_series_ref;

  assign mon_idx        = m_tdata[MIDX_W-1:0];
  assign mon_enc        = m_tdata[ENC_LO +: ENC_W];
  assign mon_turn       = m_tdata[TRN_LO +: TURN_W];
  assign mon_series     = m_tdata[SER_LO +: SERIES_W];
  assign mon_turn_ext   = {{(SERIES_W-TURN_W){mon_turn[TURN_W-1]}}, mon_turn};
  assign mon_series_ref = {{(SERIES_W-ENC_W){1'b0}}, mon_enc}
                        + {mon_turn_ext[SERIES_W-COUNT_SHIFT-1:0], {COUNT_SHIFT{1'b0}}};

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with result side free");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(mon_idx) < MOTOR_COUNT))
    else $error("motor index out of range");

  a_series: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> mon_series == mon_series_ref)
    else $error("continuous encoder disagrees with encoder and turn count");

  a_pready: assert property (@(posedge clk) pready)
    else $error("register port not ready");

endmodule

bind motor_feedback_frame_turn_tracker_top mftt_checker #(
  .MOTOR_COUNT (MOTOR_COUNT)
) u_mftt_checker (.*);

### verif/tb_top.sv
module tb_top;
  import mftt_pkg::*;

  // decoded feedback as it leaves on m_tdata, first member is the top bit
  typedef struct packed {
    logic [5:0]  fill;
    logic [34:0] series_angle_q10;
    logic [22:0] angle_q10;
    logic [29:0] series_encoder;
    logic [15:0] turn_count;
    logic [7:0]  temperature;
    logic [15:0] current_value;
    logic [15:0] motor_speed;
    logic [15:0] encoder;
    logic [1:0]  motor_index;
  } feedback_t;

  // one received frame; typed rows carry a hand-worked turn count and angle
  typedef struct packed {
    logic [10:0] id;
    logic [15:0] enc;
    logic [15:0] spd;
    logic [15:0] cur;
    logic [7:0]  temp;
    bit          typed;
    int          exp_turn;
    int          exp_angle;
  } frame_row_t;

  localparam int MOTORS       = 4;
  localparam int OUT_W        = $bits(feedback_t);
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
  localparam int WATCHDOG_MAX = 2000;  // idle cycles before giving up
  localparam int PHASE_HITS   = 80;    // decoded frames per random phase

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // [10:0] frame_id, [18:11] payload_byte0 ... [66:59] payload_byte6, rest zero
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // from bit 0 up: motor_index, encoder, motor_speed, current_value, temperature,
  // turn_count, series_encoder, angle_q10, series_angle_q10, zero fill
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // shadow of the block: registers and per-motor history
  logic [10:0] base_id;
  logic [12:0] wrap_thr;
  logic [15:0] seen_enc [MOTORS];
  int          turn_tally [MOTORS];

  feedback_t   feedback_q [$];     // decoded frames still owed by the block
  int          mismatches;
  bit          idle_on;            // random gaps and stalls on both sides
  int          hold_asked;         // bumped by the sender to request a hold-off
  int          idle_count;
  feedback_t   got_fb;
  feedback_t   want_fb;

  // directed frames, sent right after reset with base 0x201 and threshold 6400
  frame_row_t directed_rows [17] = '{
    // first frame of motor 0 at zero: no jump
    '{11'h201, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,  0, -184320},
    // full-scale rise: one turn back, top angle
    '{11'h201, 16'hffff, 16'h7fff, 16'h8000, 8'hff, 1'b1, -1, 2764755},
    // full-scale drop: one turn forward again
    '{11'h201, 16'h0000, 16'h8000, 16'h7fff, 8'h00, 1'b1,  0, -184320},
    // jump of exactly the threshold does not count
    '{11'h202, 16'd6400, 16'h0001, 16'hffff, 8'h7f, 1'b1,  0, 103680},
    '{11'h202, 16'h0000, 16'hffff, 16'h0001, 8'h80, 1'b1,  0, -184320},
    // one past the threshold counts
    '{11'h202, 16'd6401, 16'h1234, 16'h5678, 8'h55, 1'b1, -1, 103725},
    // first frame of motor 3 above the threshold counts one turn back
    '{11'h204, 16'h1fff, 16'h0102, 16'hfedc, 8'h33, 1'b1, -1, 184275},
    // motor 2 at half scale: zero degrees, rise below the threshold
    '{11'h203, 16'h1000, 16'h8000, 16'h7fff, 8'hff, 1'b1,  0, 0},
    // foreign ids on both sides of the window and at the id extremes
    '{11'h200, 16'h4444, 16'h0000, 16'h0000, 8'h00, 1'b0,  0, 0},
    '{11'h205, 16'h5555, 16'h0000, 16'h0000, 8'h00, 1'b0,  0, 0},
    '{11'h7ff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b0,  0, 0},
    '{11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0,  0, 0},
    // all-ones payload on motor 3
    '{11'h204, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1, -2, 2764755},
    '{11'h201, 16'h0064, 16'h7fff, 16'h8000, 8'h00, 1'b1,  0, -179820},
    '{11'h201, 16'he000, 16'h0f0f, 16'hf0f0, 8'h01, 1'b1, -1, 2396160},
    '{11'h201, 16'h0010, 16'haaaa, 16'h5555, 8'hfe, 1'b1,  0, -183600},
    // motor 2 back from half scale to zero: drop below the threshold, no count
    '{11'h203, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0,  0, 0}
  };

  motor_feedback_frame_turn_tracker_top #(.MOTOR_COUNT(MOTORS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode one frame against the shadow state; returns 0 for a foreign id
  function automatic bit predict_feedback(input frame_row_t f, output feedback_t r);
    int     idx;
    int     diff;
    int     thr;
    int     t;
    longint s_enc;
    longint ang;
    longint s_ang;
    r = '0;
    if (f.id < base_id) return 1'b0;
    idx = int'(f.id) - int'(base_id);
    if (idx >= MOTORS) return 1'b0;
    thr  = int'(wrap_thr);
    diff = int'(f.enc) - int'(seen_enc[idx]);
    t    = turn_tally[idx];
    // a big drop is a forward wrap, a big rise a backward one
    if (diff < -thr) begin
      if (t < int'(TURN_MAX)) t++;
    end else if (diff > thr) begin
      if (t > int'(TURN_MIN)) t--;
    end
    turn_tally[idx] = t;
    seen_enc[idx]   = f.enc;
    s_enc = longint'(f.enc) + longint'(COUNTS_PER_TURN) * t;
    ang   = longint'(f.enc) * DEG_FULL_Q10 / COUNTS_PER_TURN - DEG_HALF_Q10;
    s_ang = ang + longint'(DEG_FULL_Q10) * t;
    r.motor_index      = 2'(idx);
    r.encoder          = f.enc;
    r.motor_speed      = f.spd;
    r.current_value    = f.cur;
    r.temperature      = f.temp;
    r.turn_count       = 16'(t);
    r.series_encoder   = s_enc[29:0];
    r.angle_q10        = ang[22:0];
    r.series_angle_q10 = s_ang[34:0];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // mostly frames for live motors, with encoders often aimed at the wrap threshold
  function automatic frame_row_t random_frame();
    frame_row_t f;
    int         m;
    int         pv;
    int         v;
    int         d;
    int         pick;
    f = '0;
    m = int'($urandom_range(0, MOTORS - 1));
    if ($urandom_range(0, 99) < 15) f.id = 11'($urandom_range(0, 2047));
    else f.id = base_id + 11'(m);
    pv = (f.id >= base_id && int'(f.id) - int'(base_id) < MOTORS) ?
         int'(seen_enc[int'(f.id) - int'(base_id)]) : int'($urandom_range(0, 65535));
    pick = int'($urandom_range(0, 99));
    if (pick < 40) begin
      // straddle the threshold by one either way
      d = int'(wrap_thr) + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) d = -d;
      v = pv + d;
    end else if (pick < 60) begin
      v = pv + int'($urandom_range(0, 200)) - 100;
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 65535;
        2: v = COUNTS_PER_TURN - 1;
        default: v = COUNTS_PER_TURN;
      endcase
    end else begin
      v = int'($urandom_range(0, 65535));
    end
    if (v < 0 || v > 65535) v = int'($urandom_range(0, 65535));
    f.enc  = 16'(v);
    f.spd  = 16'($urandom_range(0, 65535));
    f.cur  = 16'($urandom_range(0, 65535));
    f.temp = 8'($urandom_range(0, 255));
    return f;
  endfunction

  // offer one frame, wait for its transaction, then log what it should give
  task automatic send_frame(input frame_row_t f, output bit hit);
    int        gap;
    feedback_t r;
    gap = idle_on ? int'($urandom_range(0, 9)) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, f.temp, f.cur[7:0], f.cur[15:8], f.spd[7:0], f.spd[15:8],
                 f.enc[7:0], f.enc[15:8], f.id};
    do @(posedge clk); while (!s_tready);
    hit = predict_feedback(f, r);
    if (hit) begin
      // hand-worked values take the place of the shadow's own
      if (f.typed) begin
        r.turn_count = 16'(f.exp_turn);
        r.angle_q10  = 23'(f.exp_angle);
      end
      feedback_q.push_back(r);
    end
  endtask

  // stop offering and let the pipe run dry, foreign frames included
  task automatic settle();
    s_tvalid <= 1'b0;
    while (feedback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; the register is hit at the access edge
  task automatic reg_access(input logic [REG_ADDR_W-1:0] addr, input bit wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    logic [31:0] rd;
    reg_access({idx, 2'b00}, 1'b0, '0, rd);
    if (rd !== want) begin
      mismatches++;
      $display("%0t: register %0d readback, expected %0h, actual %0h",
               $time, idx, want, rd);
    end
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] val);
    logic [31:0] rd;
    reg_access({idx, 2'b00}, 1'b1, val, rd);
    if (idx == REG_BASE_ID) base_id = val[10:0];
    else wrap_thr = val[12:0];
    check_reg(idx, val);
  endtask

  // result side: compare every transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_fb = m_tdata;
      if (feedback_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
      end else begin
        want_fb = feedback_q.pop_front();
        check_field("motor_index", 64'(want_fb.motor_index), 64'(got_fb.motor_index));
        check_field("encoder", 64'(want_fb.encoder), 64'(got_fb.encoder));
        check_field("motor_speed", 64'(want_fb.motor_speed), 64'(got_fb.motor_speed));
        check_field("current_value", 64'(want_fb.current_value),
                    64'(got_fb.current_value));
        check_field("temperature", 64'(want_fb.temperature), 64'(got_fb.temperature));
        check_field("turn_count", 64'(want_fb.turn_count), 64'(got_fb.turn_count));
        check_field("series_encoder", 64'(want_fb.series_encoder),
                    64'(got_fb.series_encoder));
        check_field("angle_q10", 64'(want_fb.angle_q10), 64'(got_fb.angle_q10));
        check_field("series_angle_q10", 64'(want_fb.series_angle_q10),
                    64'(got_fb.series_angle_q10));
        check_field("zero fill", 64'(want_fb.fill), 64'(got_fb.fill));
      end
    end
  end

  // receiver: random stall per transaction, one long hold-off on request
  initial begin
    int stall;
    int hold_done;
    hold_done = 0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = idle_on ? int'($urandom_range(0, 9)) : 0;
      if (hold_asked != hold_done) begin
        hold_done++;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_MAX) begin
      $display("[motor_feedback_frame_turn_tracker_top] ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    frame_row_t f;
    bit         hit;
    int         hits;
    logic [10:0] nb;
    logic [12:0] nt;
    mismatches = 0;
    hold_asked = 0;
    idle_on    = 1'b1;
    idle_count = 0;
    base_id    = BASE_RESET;
    wrap_thr   = WRAP_RESET;
    for (int i = 0; i < MOTORS; i++) begin
      seen_enc[i]   = '0;
      turn_tally[i] = 0;
    end
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers come up at their reset values
    check_reg(REG_BASE_ID, 32'(BASE_RESET));
    check_reg(REG_WRAP, 32'(WRAP_RESET));

    foreach (directed_rows[i]) send_frame(directed_rows[i], hit);
    settle();

    // random phases over several register settings, extremes first
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin nb = 11'd0;    nt = 13'd8191; end
        1: begin nb = 11'd2044; nt = 13'd0;    end
        2: begin
          nb = 11'($urandom_range(0, 2044));
          nt = 13'($urandom_range(0, 8191));
        end
        3: begin
          nb = 11'($urandom_range(0, 2044));
          nt = 13'($urandom_range(50, 1500));
        end
        default: begin nb = BASE_RESET; nt = WRAP_RESET; end
      endcase
      set_reg(REG_BASE_ID, 32'(nb));
      set_reg(REG_WRAP, 32'(nt));
      // last phase runs with no gaps on either side
      idle_on = (p != 4);
      // back pressure: receiver stops while frames keep coming
      if (p == 2) hold_asked++;
      hits = 0;
      while (hits < PHASE_HITS) begin
        f = random_frame();
        send_frame(f, hit);
        if (hit) hits++;
      end
      settle();
    end

    if (mismatches == 0 && feedback_q.size() == 0) begin
      $display("[motor_feedback_frame_turn_tracker_top] OK");
    end else begin
      $display("[motor_feedback_frame_turn_tracker_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mftt_pkg.sv
hdl/mftt_regs.sv
hdl/mftt_tracker.sv
hdl/mftt_result.sv
hdl/motor_feedback_frame_turn_tracker_top.sv
hdl/mftt_checker.sv
verif/tb_top.sv
